// ----- rtl/pdflex_pkg.sv -----
package pdflex_pkg;

  localparam int HEAD_BYTES_DEF  = 9;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;

  // token kinds
  localparam logic [4:0] K_ERROR     = 5'd0;
  localparam logic [4:0] K_EOF       = 5'd1;
  localparam logic [4:0] K_LBRACKET  = 5'd2;
  localparam logic [4:0] K_RBRACKET  = 5'd3;
  localparam logic [4:0] K_LPAREN    = 5'd4;
  localparam logic [4:0] K_RPAREN    = 5'd5;
  localparam logic [4:0] K_LANGLE    = 5'd6;
  localparam logic [4:0] K_DLANGLE   = 5'd7;
  localparam logic [4:0] K_RANGLE    = 5'd8;
  localparam logic [4:0] K_DRANGLE   = 5'd9;
  localparam logic [4:0] K_NAME      = 5'd10;
  localparam logic [4:0] K_INT       = 5'd11;
  localparam logic [4:0] K_REAL      = 5'd12;
  localparam logic [4:0] K_COMMENT   = 5'd13;
  localparam logic [4:0] K_EOF_MARK  = 5'd14;
  localparam logic [4:0] K_BIN_HDR   = 5'd15;
  localparam logic [4:0] K_VERSION   = 5'd16;
  localparam logic [4:0] K_IDENT     = 5'd17;
  localparam logic [4:0] K_R         = 5'd18;
  localparam logic [4:0] K_OBJ       = 5'd19;
  localparam logic [4:0] K_NULL      = 5'd20;
  localparam logic [4:0] K_TRUE      = 5'd21;
  localparam logic [4:0] K_XREF      = 5'd22;
  localparam logic [4:0] K_FALSE     = 5'd23;
  localparam logic [4:0] K_ENDOBJ    = 5'd24;
  localparam logic [4:0] K_STREAM    = 5'd25;
  localparam logic [4:0] K_TRAILER   = 5'd26;
  localparam logic [4:0] K_ENDSTREAM = 5'd27;
  localparam logic [4:0] K_STARTXREF = 5'd28;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_length;
    logic [31:0] token_start;
    logic        last_of_run;
  } token_t;

  typedef struct packed {
    logic   push0;
    logic   push1;
    token_t tok0;
    token_t tok1;
  } push_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_NUL || c == CH_TAB || c == CH_LF || c == CH_FF ||
           c == CH_CR || c == CH_SPACE;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_SLASH || c == CH_LBRK || c == CH_RBRK || c == CH_LPAR ||
           c == CH_RPAR || c == CH_LT || c == CH_GT;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

endpackage

// ----- rtl/pdf_token_lexer_unit.sv -----
// Flow: a request is taken into the input register, lexed once the token queue has room,
//   and its tokens are queued and offered one a cycle while out_ready_i is high.
// Throughput: one request per cycle while the queue has room for two tokens; a request's
//   two tokens leave in turn; the 4-entry queue sets how far input runs ahead of output.
// Reset: asynchronous, active low; clears the lexer mode, counters and queue pointers.
module pdf_token_lexer_unit #(
  parameter int HEAD_BYTES  = pdflex_pkg::HEAD_BYTES_DEF,
  parameter int LENGTH_BITS = pdflex_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = pdflex_pkg::OFFSET_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pdflex_pkg::in_item_t in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pdflex_pkg::token_t   out_token_o
);
  import pdflex_pkg::*;

  localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

  // Input register: holds one request until the lexer core consumes it.
  logic     in_vld_q;
  in_item_t in_q;
  logic     adv;
  logic     pop;
  logic     room;
  push_t    push;
  logic [LVL_W-1:0] level;

  // Advance only when the queue can absorb the worst case of two tokens; the bound
  // ignores a pop in the same cycle so no path runs from out_ready_i to in_ready_o.
  assign room       = level <= LVL_W'(QUEUE_DEPTH - 2);
  assign adv        = in_vld_q & room;
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_item_i;
  end

  // Lexer core: mode, length, origin, offset and the head bytes of the open token.
  pdflex_core #(
    .HEAD_BYTES (HEAD_BYTES),
    .LENGTH_BITS(LENGTH_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .item_i(in_q),
    .push_o(push)
  );

  // Token queue: parts the lexer from the consumer and serializes token pairs.
  assign out_valid_o = level != '0;
  assign pop         = out_valid_o & out_ready_i;

  pdflex_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (out_token_o),
    .level_o(level)
  );

  // A second token of one request never appears without a first.
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push1 |-> push.push0)
    else $error("second token pushed without a first");

  // The last pushed token of a request, and only it, carries last_of_run.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push1 |-> (push.tok1.last_of_run && !push.tok0.last_of_run))
    else $error("last_of_run wrong on token pair");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.push0 && !push.push1) |-> push.tok0.last_of_run)
    else $error("last_of_run missing on single token");

  // The queue never overflows: in the cycle after a push its level stays within depth.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.push0 || push.push1) |=> (level <= LVL_W'(QUEUE_DEPTH)))
    else $error("token queue overflow");

endmodule

// ----- rtl/pdflex_core.sv -----
module pdflex_core #(
  parameter int HEAD_BYTES  = pdflex_pkg::HEAD_BYTES_DEF,
  parameter int LENGTH_BITS = pdflex_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = pdflex_pkg::OFFSET_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  pdflex_pkg::in_item_t item_i,
  output pdflex_pkg::push_t    push_o
);
  import pdflex_pkg::*;

  localparam int IDX_W = $clog2(HEAD_BYTES);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  typedef enum logic [3:0] {
    M_START, M_NAME, M_LANGLE, M_RANGLE, M_COMMENT, M_IDENT, M_NUMBER, M_REAL, M_SKIP
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic [OFFSET_BITS-1:0] origin_q, origin_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [7:0]             head_q [HEAD_BYTES];

  logic             hw_en;
  logic [IDX_W-1:0] hw_idx;
  logic             e0, e1;
  token_t           t0, t1;

  // compare the first n head bytes against a right-aligned string
  function automatic logic head_eq(input logic [71:0] s, input int n);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 9; i++) begin
      if (i < n) begin
        if (head_q[i] != s[8*(n-1-i) +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [4:0] ident_kind();
    logic [4:0] k;
    k = K_IDENT;
    if (count_q == LENGTH_BITS'(1)) begin
      if (head_q[0] == CH_R) k = K_R;
    end else if (count_q == LENGTH_BITS'(3)) begin
      if (head_eq(72'("obj"), 3)) k = K_OBJ;
    end else if (count_q == LENGTH_BITS'(4)) begin
      if (head_eq(72'("null"), 4)) k = K_NULL;
      else if (head_eq(72'("true"), 4)) k = K_TRUE;
      else if (head_eq(72'("xref"), 4)) k = K_XREF;
    end else if (count_q == LENGTH_BITS'(5)) begin
      if (head_eq(72'("false"), 5)) k = K_FALSE;
    end else if (count_q == LENGTH_BITS'(6)) begin
      if (head_eq(72'("endobj"), 6)) k = K_ENDOBJ;
      else if (head_eq(72'("stream"), 6)) k = K_STREAM;
    end else if (count_q == LENGTH_BITS'(7)) begin
      if (head_eq(72'("trailer"), 7)) k = K_TRAILER;
    end else if (count_q == LENGTH_BITS'(9)) begin
      if (head_eq(72'("endstream"), 9)) k = K_ENDSTREAM;
      else if (head_eq(72'("startxref"), 9)) k = K_STARTXREF;
    end
    return k;
  endfunction

  function automatic logic [4:0] comment_kind();
    logic [4:0] k;
    k = K_COMMENT;
    if (count_q >= LENGTH_BITS'(5) && head_eq(72'("%%EOF"), 5)) begin
      k = K_EOF_MARK;
    end else if (count_q >= LENGTH_BITS'(5) && head_q[1][7] && head_q[2][7] &&
                 head_q[3][7] && head_q[4][7]) begin
      k = K_BIN_HDR;
    end else if (count_q >= LENGTH_BITS'(8) && head_eq(72'("%PDF-"), 5) &&
                 head_q[6] == CH_DOT && is_digit(head_q[5]) && is_digit(head_q[7])) begin
      k = K_VERSION;
    end
    return k;
  endfunction

  function automatic token_t mk_tok(input logic [4:0] kind,
                                    input logic [LENGTH_BITS-1:0] len,
                                    input logic [OFFSET_BITS-1:0] start);
    token_t     t;
    logic [31:0] lw;
    logic [63:0] sw;
    lw = 32'(len);
    sw = 64'(start);
    t.token_kind   = kind;
    t.token_length = (lw > 32'h0000_FFFF) ? 16'hFFFF : lw[15:0];
    t.token_start  = sw[31:0];
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       redo;
    logic       dispatch;
    logic       ds_emit;
    token_t     ds_tok;
    logic [4:0] k;

    c        = item_i.data_byte;
    redo     = 1'b0;
    dispatch = 1'b0;
    ds_emit  = 1'b0;
    ds_tok   = mk_tok(K_ERROR, '0, offset_q);
    k        = K_IDENT;
    mode_d   = mode_q;
    count_d  = count_q;
    origin_d = origin_q;
    offset_d = offset_q;
    hw_en    = 1'b0;
    hw_idx   = count_q[IDX_W-1:0];
    e0       = 1'b0;
    e1       = 1'b0;
    t0       = mk_tok(K_ERROR, '0, offset_q);
    t1       = mk_tok(K_ERROR, '0, offset_q);

    if (item_i.op == OP_EOF) begin
      e0      = 1'b1;
      t0      = mk_tok((mode_q == M_SKIP) ? K_ERROR : K_EOF, '0, offset_q);
      mode_d  = M_START;
      count_d = '0;
    end else begin
      offset_d = offset_q + OFFSET_BITS'(1);
      unique case (mode_q)
        M_NAME, M_IDENT: begin
          if (!is_ws(c) && !is_delim(c)) begin
            hw_en   = count_q < LENGTH_BITS'(HEAD_BYTES);
            count_d = (count_q == LEN_MAX) ? count_q : count_q + LENGTH_BITS'(1);
          end else if (mode_q == M_NAME) begin
            e0     = 1'b1;
            t0     = mk_tok(K_NAME, count_q, origin_q);
            mode_d = M_START;
            redo   = 1'b1;
          end else begin
            k = ident_kind();
            if (k == K_STREAM) begin
              if (c == CH_LF) begin
                e0     = 1'b1;
                t0     = mk_tok(K_STREAM, count_q, origin_q);
                mode_d = M_START;
              end else begin
                mode_d = M_SKIP;
              end
            end else begin
              e0     = 1'b1;
              t0     = mk_tok(k, count_q, origin_q);
              mode_d = M_START;
              redo   = 1'b1;
            end
          end
        end
        M_SKIP: begin
          if (c == CH_LF) begin
            e0     = 1'b1;
            t0     = mk_tok(K_STREAM, count_q, origin_q);
            mode_d = M_START;
          end
        end
        M_LANGLE, M_RANGLE: begin
          mode_d = M_START;
          e0     = 1'b1;
          if (mode_q == M_LANGLE) begin
            if (c == CH_LT) begin
              t0 = mk_tok(K_DLANGLE, '0, origin_q);
            end else begin
              t0   = mk_tok(K_LANGLE, '0, origin_q);
              redo = 1'b1;
            end
          end else begin
            if (c == CH_GT) begin
              t0 = mk_tok(K_DRANGLE, '0, origin_q);
            end else begin
              t0   = mk_tok(K_RANGLE, '0, origin_q);
              redo = 1'b1;
            end
          end
        end
        M_COMMENT: begin
          if (c == CH_CR || c == CH_LF) begin
            e0     = 1'b1;
            t0     = mk_tok(comment_kind(), count_q, origin_q);
            mode_d = M_START;
          end else begin
            hw_en   = count_q < LENGTH_BITS'(HEAD_BYTES);
            count_d = (count_q == LEN_MAX) ? count_q : count_q + LENGTH_BITS'(1);
          end
        end
        M_NUMBER, M_REAL: begin
          if (is_digit(c) || c == CH_DOT) begin
            hw_en   = count_q < LENGTH_BITS'(HEAD_BYTES);
            count_d = (count_q == LEN_MAX) ? count_q : count_q + LENGTH_BITS'(1);
            if (c == CH_DOT) mode_d = M_REAL;
          end else begin
            e0     = 1'b1;
            t0     = mk_tok((mode_q == M_NUMBER) ? K_INT : K_REAL, count_q, origin_q);
            mode_d = M_START;
            redo   = 1'b1;
          end
        end
        default: dispatch = 1'b1;
      endcase

      // start-state dispatch, also for a terminator handed back by the first pass
      if (dispatch || redo) begin
        mode_d = M_START;
        unique case (c)
          CH_SLASH, CH_PCT, CH_PLUS, CH_MINUS: begin
            mode_d   = (c == CH_SLASH) ? M_NAME : ((c == CH_PCT) ? M_COMMENT : M_REAL);
            origin_d = offset_q;
            count_d  = LENGTH_BITS'(1);
            hw_en    = 1'b1;
            hw_idx   = '0;
          end
          CH_LT, CH_GT: begin
            mode_d   = (c == CH_LT) ? M_LANGLE : M_RANGLE;
            origin_d = offset_q;
            count_d  = '0;
          end
          CH_LBRK: begin ds_emit = 1'b1; ds_tok = mk_tok(K_LBRACKET, '0, offset_q); end
          CH_RBRK: begin ds_emit = 1'b1; ds_tok = mk_tok(K_RBRACKET, '0, offset_q); end
          CH_LPAR: begin ds_emit = 1'b1; ds_tok = mk_tok(K_LPAREN, '0, offset_q); end
          CH_RPAR: begin ds_emit = 1'b1; ds_tok = mk_tok(K_RPAREN, '0, offset_q); end
          default: begin
            if (is_alpha(c) || is_digit(c)) begin
              mode_d   = is_alpha(c) ? M_IDENT : M_NUMBER;
              origin_d = offset_q;
              count_d  = LENGTH_BITS'(1);
              hw_en    = 1'b1;
              hw_idx   = '0;
            end else if (!is_ws(c)) begin
              ds_emit = 1'b1;
              ds_tok  = mk_tok(K_ERROR, '0, offset_q);
            end
          end
        endcase
        if (redo) begin
          e1 = ds_emit;
          t1 = ds_tok;
        end else begin
          e0 = ds_emit;
          t0 = ds_tok;
        end
      end
    end

    t0.last_of_run = !e1;
    t1.last_of_run = 1'b1;
  end

  assign push_o.push0 = adv_i & e0;
  assign push_o.push1 = adv_i & e1;
  assign push_o.tok0  = t0;
  assign push_o.tok1  = t1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_START;
      count_q  <= '0;
      origin_q <= '0;
      offset_q <= '0;
    end else if (adv_i) begin
      mode_q   <= mode_d;
      count_q  <= count_d;
      origin_q <= origin_d;
      offset_q <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      if (adv_i && hw_en && hw_idx == IDX_W'(i)) head_q[i] <= item_i.data_byte;
    end
  end

endmodule

// ----- rtl/pdflex_queue.sv -----
module pdflex_queue #(
  parameter int DEPTH = pdflex_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pdflex_pkg::push_t             push_i,
  input  logic                          pop_i,
  output pdflex_pkg::token_t            head_o,
  output logic [$clog2(DEPTH+1)-1:0]    level_o
);
  import pdflex_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH+1);

  token_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q, wr_d, rd_d, wr_nx;
  logic [LVL_W-1:0] level_q, level_d;
  logic             any_push, two_push;
  token_t           first_tok;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    any_push  = push_i.push0 | push_i.push1;
    two_push  = push_i.push0 & push_i.push1;
    first_tok = push_i.push0 ? push_i.tok0 : push_i.tok1;
    wr_nx     = inc(wr_q);
    wr_d      = two_push ? inc(wr_nx) : (any_push ? wr_nx : wr_q);
    rd_d      = pop_i ? inc(rd_q) : rd_q;
    level_d   = level_q + LVL_W'(push_i.push0) + LVL_W'(push_i.push1) - LVL_W'(pop_i);
  end

  assign head_o  = mem_q[rd_q];
  assign level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (any_push && wr_q == PTR_W'(i)) mem_q[i] <= first_tok;
      if (two_push && wr_nx == PTR_W'(i)) mem_q[i] <= push_i.tok1;
    end
  end

endmodule
